### hw/rtl/fmbq_pkg.sv
package fmbq_pkg;

    // Stream payload layout
    localparam int MODE_W      = 3;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // Defaults for the top level parameters
    localparam int DEF_QUEUE_CAPACITY = 1024;
    localparam int DEF_WORD_WIDTH     = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT  = 3'd0,
        MODE_PUSH_MIDDLE = 3'd1,
        MODE_PUSH_BACK   = 3'd2,
        MODE_POP_FRONT   = 3'd3,
        MODE_POP_MIDDLE  = 3'd4,
        MODE_POP_BACK    = 3'd5
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Where the result word comes from in the write-back cycle
    typedef enum logic [1:0] {
        RES_ZERO  = 2'd0,
        RES_FRONT = 2'd1,
        RES_BACK  = 2'd2,
        RES_EMPTY = 2'd3
    } res_sel_t;

    // Write-back plan worked out when a beat is taken
    typedef struct packed {
        logic     front_we;
        logic     front_from_back;
        logic     back_we;
        logic     back_from_front;
        res_sel_t res_sel;
        status_t  status;
    } fmbq_plan_t;

endpackage

### hw/rtl/fmbq_ram.sv
module fmbq_ram
    import fmbq_pkg::*;
#(
    parameter int WIDTH = DEF_WORD_WIDTH,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/fmbq_ctrl.sv
module fmbq_ctrl
    import fmbq_pkg::*;
#(
    parameter int QUEUE_CAPACITY = DEF_QUEUE_CAPACITY,
    parameter int WORD_WIDTH     = DEF_WORD_WIDTH,
    localparam int HALF_DEPTH = (QUEUE_CAPACITY + 1) / 2,
    localparam int IW = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1,
    localparam int CW = $clog2(HALF_DEPTH + 1)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  mode_t                        mode,
    input  logic signed [VALUE_W-1:0]    push_value,
    output logic [IW-1:0]                front_raddr,
    output logic [IW-1:0]                back_raddr,
    output logic [IW-1:0]                front_waddr,
    output logic [IW-1:0]                back_waddr,
    output logic [WORD_WIDTH-1:0]        push_word,
    output fmbq_plan_t                   plan,
    output logic [CW-1:0]                front_count,
    output logic [CW-1:0]                back_count
);

    localparam int SW = ((IW > CW) ? IW : CW) + 1;
    localparam logic [CW:0] CAP_V = (CW + 1)'(QUEUE_CAPACITY);

    // Ring index helpers; ring_add wraps only once, so it is exact only for offsets up to the ring depth
    function automatic logic [IW-1:0] ring_add(logic [IW-1:0] h, logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(h) + SW'(off);
        if (s >= SW'(HALF_DEPTH))
        begin
            s = s - SW'(HALF_DEPTH);
        end
        return s[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] ring_inc(logic [IW-1:0] h);
        return (h == IW'(HALF_DEPTH - 1)) ? '0 : h + 1'b1;
    endfunction

    function automatic logic [IW-1:0] ring_dec(logic [IW-1:0] h);
        return (h == '0) ? IW'(HALF_DEPTH - 1) : h - 1'b1;
    endfunction

    logic [IW-1:0] fh_reg, fh_next, bh_reg, bh_next;
    logic [CW-1:0] fcnt_reg, fcnt_next, bcnt_reg, bcnt_next;
    fmbq_plan_t    plan_reg, plan_next;
    logic [IW-1:0] fwa_reg, fwa_next, bwa_reg, bwa_next;
    logic [WORD_WIDTH-1:0] word_reg;

    logic [IW-1:0] f_last, f_end, f_hdec, f_hinc;
    logic [IW-1:0] b_last, b_end, b_hdec, b_hinc;
    logic          full, empty, f_ahead, even;

    // Candidate ring positions for this beat
    always_comb
    begin
        f_last  = ring_add(fh_reg, fcnt_reg - 1'b1);
        f_end   = ring_add(fh_reg, fcnt_reg);
        f_hdec  = ring_dec(fh_reg);
        f_hinc  = ring_inc(fh_reg);
        b_last  = ring_add(bh_reg, bcnt_reg - 1'b1);
        b_end   = ring_add(bh_reg, bcnt_reg);
        b_hdec  = ring_dec(bh_reg);
        b_hinc  = ring_inc(bh_reg);
        full    = ((CW + 1)'(fcnt_reg) + (CW + 1)'(bcnt_reg)) >= CAP_V;
        empty   = (fcnt_reg == '0);
        f_ahead = (fcnt_reg > bcnt_reg);
        even    = (fcnt_reg == bcnt_reg);
    end

    // Plan reads now, writes in the next cycle
    always_comb
    begin
        fh_next     = fh_reg;
        bh_next     = bh_reg;
        fcnt_next   = fcnt_reg;
        bcnt_next   = bcnt_reg;
        front_raddr = f_last;
        back_raddr  = bh_reg;
        fwa_next    = f_end;
        bwa_next    = b_end;
        plan_next   = '{front_we: 1'b0, front_from_back: 1'b0, back_we: 1'b0,
                        back_from_front: 1'b0, res_sel: RES_ZERO, status: ST_OK};
        case (mode)
            MODE_PUSH_FRONT:
            begin
                if (full)
                begin
                    plan_next.status = ST_FULL;
                end
                else
                begin
                    // front's last word moves to back's head first
                    if (f_ahead)
                    begin
                        front_raddr               = f_last;
                        plan_next.back_we         = 1'b1;
                        plan_next.back_from_front = 1'b1;
                        bwa_next                  = b_hdec;
                        bh_next                   = b_hdec;
                        bcnt_next                 = bcnt_reg + 1'b1;
                    end
                    else
                    begin
                        fcnt_next = fcnt_reg + 1'b1;
                    end
                    plan_next.front_we = 1'b1;
                    fwa_next           = f_hdec;
                    fh_next            = f_hdec;
                end
            end
            MODE_PUSH_MIDDLE:
            begin
                if (full)
                begin
                    plan_next.status = ST_FULL;
                end
                else if (f_ahead)
                begin
                    // old middle goes to back, new word takes its slot
                    front_raddr               = f_last;
                    plan_next.back_we         = 1'b1;
                    plan_next.back_from_front = 1'b1;
                    bwa_next                  = b_hdec;
                    bh_next                   = b_hdec;
                    bcnt_next                 = bcnt_reg + 1'b1;
                    plan_next.front_we        = 1'b1;
                    fwa_next                  = f_last;
                end
                else
                begin
                    plan_next.front_we = 1'b1;
                    fwa_next           = f_end;
                    fcnt_next          = fcnt_reg + 1'b1;
                end
            end
            MODE_PUSH_BACK:
            begin
                if (full)
                begin
                    plan_next.status = ST_FULL;
                end
                else if (even && empty)
                begin
                    // new word lands straight in the front half
                    plan_next.front_we = 1'b1;
                    fwa_next           = f_end;
                    fcnt_next          = fcnt_reg + 1'b1;
                end
                else if (even)
                begin
                    back_raddr                = bh_reg;
                    plan_next.front_we        = 1'b1;
                    plan_next.front_from_back = 1'b1;
                    fwa_next                  = f_end;
                    fcnt_next                 = fcnt_reg + 1'b1;
                    plan_next.back_we         = 1'b1;
                    bwa_next                  = b_end;
                    bh_next                   = b_hinc;
                end
                else
                begin
                    plan_next.back_we = 1'b1;
                    bwa_next          = b_end;
                    bcnt_next         = bcnt_reg + 1'b1;
                end
            end
            MODE_POP_FRONT:
            begin
                if (empty)
                begin
                    plan_next.res_sel = RES_EMPTY;
                    plan_next.status  = ST_EMPTY;
                end
                else
                begin
                    front_raddr       = fh_reg;
                    plan_next.res_sel = RES_FRONT;
                    fh_next           = f_hinc;
                    if (even)
                    begin
                        back_raddr                = bh_reg;
                        plan_next.front_we        = 1'b1;
                        plan_next.front_from_back = 1'b1;
                        fwa_next                  = f_end;
                        bh_next                   = b_hinc;
                        bcnt_next                 = bcnt_reg - 1'b1;
                    end
                    else
                    begin
                        fcnt_next = fcnt_reg - 1'b1;
                    end
                end
            end
            MODE_POP_MIDDLE:
            begin
                if (empty)
                begin
                    plan_next.res_sel = RES_EMPTY;
                    plan_next.status  = ST_EMPTY;
                end
                else
                begin
                    front_raddr       = f_last;
                    plan_next.res_sel = RES_FRONT;
                    if (even)
                    begin
                        // back's head refills the vacated middle slot
                        back_raddr                = bh_reg;
                        plan_next.front_we        = 1'b1;
                        plan_next.front_from_back = 1'b1;
                        fwa_next                  = f_last;
                        bh_next                   = b_hinc;
                        bcnt_next                 = bcnt_reg - 1'b1;
                    end
                    else
                    begin
                        fcnt_next = fcnt_reg - 1'b1;
                    end
                end
            end
            MODE_POP_BACK:
            begin
                if (empty)
                begin
                    plan_next.res_sel = RES_EMPTY;
                    plan_next.status  = ST_EMPTY;
                end
                else if (bcnt_reg == '0)
                begin
                    // single word sits in the front half
                    front_raddr       = f_last;
                    plan_next.res_sel = RES_FRONT;
                    fcnt_next         = fcnt_reg - 1'b1;
                end
                else
                begin
                    back_raddr        = b_last;
                    plan_next.res_sel = RES_BACK;
                    if (f_ahead)
                    begin
                        front_raddr               = f_last;
                        plan_next.back_we         = 1'b1;
                        plan_next.back_from_front = 1'b1;
                        bwa_next                  = b_hdec;
                        bh_next                   = b_hdec;
                        fcnt_next                 = fcnt_reg - 1'b1;
                    end
                    else
                    begin
                        bcnt_next = bcnt_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                // unused modes leave the queue alone
                plan_next.status = ST_OK;
            end
        endcase
    end

    // Pointer and plan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fh_reg   <= '0;
            bh_reg   <= '0;
            fcnt_reg <= '0;
            bcnt_reg <= '0;
            plan_reg <= '0;
        end
        else if (accept)
        begin
            fh_reg   <= fh_next;
            bh_reg   <= bh_next;
            fcnt_reg <= fcnt_next;
            bcnt_reg <= bcnt_next;
            plan_reg <= plan_next;
        end
    end

    // Write-back addresses and data
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwa_reg  <= fwa_next;
            bwa_reg  <= bwa_next;
            word_reg <= WORD_WIDTH'(push_value);
        end
    end

    assign front_waddr = fwa_reg;
    assign back_waddr  = bwa_reg;
    assign push_word   = word_reg;
    assign plan        = plan_reg;
    assign front_count = fcnt_reg;
    assign back_count  = bcnt_reg;

endmodule

### hw/rtl/front_middle_back_queue.sv
// An input beat is taken only in S_IDLE. Each item reads both half memories when
// it is taken and writes them back in S_EXEC, so a new item waits until the last
// one has written back and its result has a free slot in the output register.
// Reset: asynchronous, active low; clears head pointers, counts and handshake
// state. The half memories are not cleared and need no clearing pass.
module front_middle_back_queue
    import fmbq_pkg::*;
#(
    parameter int QUEUE_CAPACITY = DEF_QUEUE_CAPACITY,
    parameter int WORD_WIDTH     = DEF_WORD_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // mode[2:0], push_value[34:3], zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // pop_value[31:0], status[33:32], zero pad
);

    localparam int HALF_DEPTH = (QUEUE_CAPACITY + 1) / 2;
    localparam int IW = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
    localparam int CW = $clog2(HALF_DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                  state_reg;
    logic                    m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]  m_tdata_reg;
    logic                    accept;
    logic                    exec;

    logic [IW-1:0]           front_raddr, back_raddr, front_waddr, back_waddr;
    logic [WORD_WIDTH-1:0]   push_word, front_rdata, back_rdata;
    logic [WORD_WIDTH-1:0]   front_wdata, back_wdata;
    fmbq_plan_t              plan;
    logic [CW-1:0]           front_count, back_count;
    logic [VALUE_W-1:0]      pop_value;

    // Take a beat only when the output slot is free by the write-back cycle
    assign s_tready = rst_n && (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign exec     = (state_reg == S_EXEC);

    fmbq_ctrl #(
        .QUEUE_CAPACITY (QUEUE_CAPACITY),
        .WORD_WIDTH     (WORD_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .mode        (mode_t'(s_tdata[MODE_W-1:0])),
        .push_value  (s_tdata[MODE_W +: VALUE_W]),
        .front_raddr (front_raddr),
        .back_raddr  (back_raddr),
        .front_waddr (front_waddr),
        .back_waddr  (back_waddr),
        .push_word   (push_word),
        .plan        (plan),
        .front_count (front_count),
        .back_count  (back_count)
    );

    // Write data: the pushed word or the word crossing the boundary
    assign front_wdata = plan.front_from_back ? back_rdata : push_word;
    assign back_wdata  = plan.back_from_front ? front_rdata : push_word;

    fmbq_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (HALF_DEPTH)
    ) u_front_ram (
        .clk   (clk),
        .we    (exec && plan.front_we),
        .waddr (front_waddr),
        .wdata (front_wdata),
        .re    (accept),
        .raddr (front_raddr),
        .rdata (front_rdata)
    );

    fmbq_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (HALF_DEPTH)
    ) u_back_ram (
        .clk   (clk),
        .we    (exec && plan.back_we),
        .waddr (back_waddr),
        .wdata (back_wdata),
        .re    (accept),
        .raddr (back_raddr),
        .rdata (back_rdata)
    );

    // Result word selection
    always_comb
    begin
        case (plan.res_sel)
            RES_FRONT: pop_value = VALUE_W'($signed(front_rdata));
            RES_BACK:  pop_value = VALUE_W'($signed(back_rdata));
            RES_EMPTY: pop_value = '1;
            default:   pop_value = '0;
        endcase
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (m_tvalid_reg && m_tready)
                    begin
                        m_tvalid_reg <= 1'b0;
                    end
                    if (accept)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    m_tvalid_reg <= 1'b1;
                    m_tdata_reg  <= OUT_TDATA_W'({plan.status, pop_value});
                    state_reg    <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Every taken beat yields a result once its S_EXEC write-back has passed
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 m_tvalid)
        else $error("result beat missing after input beat");

    // A waiting result is never overtaken
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while result stalled");

    // Front half holds as many words as the back half or one more
    assert property (@(posedge clk) disable iff (!rst_n)
        (front_count >= back_count) && (front_count <= back_count + 1))
        else $error("halves out of balance");

    // Occupancy never passes capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        (front_count + back_count) <= QUEUE_CAPACITY)
        else $error("queue over capacity");

endmodule
